FILE: hw/rtl/ooct_pkg.sv
// ooct_pkg: shared types, field widths and codes for the on/off cycle timer
// used by every module under hw/rtl; no dependencies of its own
`timescale 1ns / 1ps

package ooct_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned InDataW   = 40;   // now_ms + force_level, padded to bytes
  localparam int unsigned InUserW   = 1;    // operation
  localparam int unsigned OutDataW  = 104;  // 98 bits of result, padded to bytes

  // operation codes
  localparam logic OP_RUN   = 1'b0;
  localparam logic OP_FORCE = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ENABLE        = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INITIAL_DELAY = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ON_TIME       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OFF_TIME      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ON_BUDGET     = 3'd4;

  // one input transaction
  typedef struct packed {
    logic             operation;
    logic [TimeW-1:0] now_ms;
    logic             force_level;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic             status;
    logic             output_on;
    logic [TimeW-1:0] cycles_done;
    logic [TimeW-1:0] phase_elapsed;
    logic [TimeW-1:0] on_time_sum;
  } result_t;

endpackage

FILE: hw/rtl/ooct_in_stage.sv
// ooct_in_stage: input register of the timer, takes one transaction a cycle
// unless the result register is stalled; depends on ooct_pkg
`timescale 1ns / 1ps

module ooct_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ooct_pkg::item_t    in_item_i,
  input  logic               advance_i,
  output ooct_pkg::item_t    item_o,
  output logic               item_valid_o
);

  logic            valid_q, valid_d;
  ooct_pkg::item_t item_q;

  // register is free when empty or when its item moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_valid_i ? 1'b1 : (valid_q && !advance_i);

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_ready_o ? valid_d : valid_q;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = valid_q;

endmodule

FILE: hw/rtl/ooct_core.sv
// ooct_core: configuration registers, timer state and the per-item step logic
// depends on ooct_pkg
`timescale 1ns / 1ps

module ooct_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ooct_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ooct_pkg::TimeW-1:0]    cfg_wdata_i,
  input  ooct_pkg::item_t               item_i,
  input  logic                          step_i,
  output ooct_pkg::result_t             result_o
);

  // configuration
  logic                       enable_q;
  logic [ooct_pkg::TimeW-1:0] initial_delay_q, on_time_q, off_time_q, on_budget_q;

  // timer state
  logic                       armed_q, armed_d;
  logic                       level_q, level_d;
  logic [ooct_pkg::TimeW-1:0] deadline_q, deadline_d;
  logic [ooct_pkg::TimeW-1:0] elapsed_q, elapsed_d;
  logic [ooct_pkg::TimeW-1:0] cycle_total_q, cycle_total_d;
  logic [ooct_pkg::TimeW-1:0] on_sum_q, on_sum_d;
  logic                       status;

  // step helpers
  logic [ooct_pkg::TimeW-1:0] cur_len, force_len, diff, phase_base;
  logic                       budget_hit;

  // register writes, out-of-range indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q        <= 1'b0;
      initial_delay_q <= '0;
      on_time_q       <= '0;
      off_time_q      <= '0;
      on_budget_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ooct_pkg::REG_ENABLE:        enable_q        <= cfg_wdata_i[0];
        ooct_pkg::REG_INITIAL_DELAY: initial_delay_q <= cfg_wdata_i;
        ooct_pkg::REG_ON_TIME:       on_time_q       <= cfg_wdata_i;
        ooct_pkg::REG_OFF_TIME:      off_time_q      <= cfg_wdata_i;
        ooct_pkg::REG_ON_BUDGET:     on_budget_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cur_len     = level_q ? on_time_q : off_time_q;
  assign force_len   = item_i.force_level ? on_time_q : off_time_q;
  assign phase_base  = deadline_q - cur_len;
  assign diff        = item_i.now_ms - deadline_q;
  assign budget_hit  = (on_budget_q != '0) && (cycle_total_q >= on_budget_q);

  // one step of the timer
  always_comb begin
    armed_d       = armed_q;
    level_d       = level_q;
    deadline_d    = deadline_q;
    elapsed_d     = elapsed_q;
    cycle_total_d = cycle_total_q;
    on_sum_d      = on_sum_q;
    status        = 1'b0;
    if (item_i.operation == ooct_pkg::OP_FORCE) begin
      level_d    = item_i.force_level;
      deadline_d = item_i.now_ms + force_len;
      status     = 1'b1;
    end else if (!enable_q) begin
      level_d   = 1'b0;
      elapsed_d = '0;
    end else if (!armed_q) begin
      armed_d    = 1'b1;
      deadline_d = item_i.now_ms + initial_delay_q;
      elapsed_d  = '0;
    end else begin
      elapsed_d = item_i.now_ms - phase_base;
      // signed wrap compare: due when now - deadline is not negative
      if (!diff[ooct_pkg::TimeW-1]) begin
        if (level_q) begin
          level_d    = 1'b0;
          on_sum_d   = on_sum_q + on_time_q;
          deadline_d = item_i.now_ms + off_time_q;
          status     = 1'b1;
        end else if (!budget_hit) begin
          level_d       = 1'b1;
          cycle_total_d = cycle_total_q + 32'd1;
          deadline_d    = item_i.now_ms + on_time_q;
          status        = 1'b1;
        end
      end
    end
  end

  // state update when the item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q       <= 1'b0;
      level_q       <= 1'b0;
      deadline_q    <= '0;
      elapsed_q     <= '0;
      cycle_total_q <= '0;
      on_sum_q      <= '0;
    end else if (step_i) begin
      armed_q       <= armed_d;
      level_q       <= level_d;
      deadline_q    <= deadline_d;
      elapsed_q     <= elapsed_d;
      cycle_total_q <= cycle_total_d;
      on_sum_q      <= on_sum_d;
    end
  end

  assign result_o.status        = status;
  assign result_o.output_on     = level_d;
  assign result_o.cycles_done   = cycle_total_d;
  assign result_o.phase_elapsed = elapsed_d;
  assign result_o.on_time_sum   = on_sum_d;

endmodule

FILE: hw/rtl/ooct_out_stage.sv
// ooct_out_stage: result register facing the master-side stream
// depends on ooct_pkg
`timescale 1ns / 1ps

module ooct_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  ooct_pkg::result_t  result_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ooct_pkg::result_t  result_o
);

  logic              valid_q, valid_d;
  ooct_pkg::result_t result_q;

  // free when empty or when the held result is taken this cycle
  assign space_o = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && !out_ready_i);

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

FILE: hw/rtl/on_off_cycle_timer.sv
// on_off_cycle_timer: cyclic on/off timer with an initial delay, top level
// Usage:
//   Slave stream carries one step per transaction: tuser holds the operation
//   (run or force), tdata the millisecond timestamp and the force level.
//   Master stream returns exactly one result per step: toggle status, output
//   level, on-cycle count, time in the current phase and total on-time.
//   Registers are written through cfg_we_i / cfg_index_i / cfg_wdata_i;
//   the user must write them only while no step is in flight, the block
//   does not enforce this; indexes past the on-budget register are ignored.
// Timing:
//   The input transaction is captured in the input register, then the step
//   logic (32-bit adds and compares) feeds the result register, where the
//   timer state updates too. Throughput is one step per cycle while the
//   receiver takes each result.
// Reset and stall:
//   Reset clears configuration, timer state and both valid flags.
//   When the receiver stalls, the result holds, one more step waits in the
//   input register, and s_axis_tready drops until the result is taken.
`timescale 1ns / 1ps

module on_off_cycle_timer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [ooct_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ooct_pkg::TimeW-1:0]      cfg_wdata_i,
  // slave stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ooct_pkg::InDataW-1:0]    s_axis_tdata,  // now_ms[31:0], force_level[32]
  input  logic [ooct_pkg::InUserW-1:0]    s_axis_tuser,  // operation[0]
  // master stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status[0], output_on[1], cycles_done[33:2], phase_elapsed[65:34], on_time_sum[97:66]
  output logic [ooct_pkg::OutDataW-1:0]   m_axis_tdata
);

  ooct_pkg::item_t   in_item, stage_item;
  ooct_pkg::result_t step_result, out_result;
  logic              stage_valid;
  logic              advance;
  logic              step;

  // unpack the incoming transaction
  assign in_item.operation   = s_axis_tuser[0];
  assign in_item.now_ms      = s_axis_tdata[ooct_pkg::TimeW-1:0];
  assign in_item.force_level = s_axis_tdata[ooct_pkg::TimeW];

  ooct_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .item_o       (stage_item),
    .item_valid_o (stage_valid)
  );

  assign step = stage_valid && advance;

  ooct_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (stage_item),
    .step_i      (step),
    .result_o    (step_result)
  );

  ooct_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (step_result),
    .space_o     (advance),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (out_result)
  );

  // pack the result, first field in the lowest bits
  assign m_axis_tdata = {6'b0, out_result.on_time_sum, out_result.phase_elapsed,
                         out_result.cycles_done, out_result.output_on, out_result.status};

endmodule

FILE: hw/rtl/ooct_checker.sv
// ooct_checker: port-level assertions for on_off_cycle_timer, bound to the top
// depends on ooct_pkg
`timescale 1ns / 1ps

module ooct_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ooct_pkg::OutDataW-1:0]   m_axis_tdata
);

  logic                       seen_q;
  logic [ooct_pkg::TimeW-1:0] last_cycles_q;
  logic [ooct_pkg::TimeW-1:0] cycles_now;
  logic                       out_fire;

  assign out_fire   = m_axis_tvalid && m_axis_tready;
  assign cycles_now = m_axis_tdata[ooct_pkg::TimeW+1:2];

  // remember the on-cycle count of the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q        <= 1'b0;
      last_cycles_q <= '0;
    end else if (out_fire) begin
      seen_q        <= 1'b1;
      last_cycles_q <= cycles_now;
    end
  end

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input back-pressure only while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with no waiting result");

  // on-cycle count moves by at most one per step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && seen_q |->
      cycles_now == last_cycles_q || cycles_now == last_cycles_q + 32'd1)
    else $error("on-cycle count jumped");

  // a counted on-cycle is a toggle to on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && seen_q && cycles_now != last_cycles_q |->
      m_axis_tdata[0] && m_axis_tdata[1])
    else $error("on-cycle counted without toggle to on");

endmodule

bind on_off_cycle_timer ooct_checker u_ooct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
